>>> hw/rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and fixed-point helpers for the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int LEAD_BITS  = $clog2(WORD_BITS);
    localparam int NORM_BITS  = 30;                 // normalized magnitude width
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int N2_BITS    = SQ_BITS + 2;
    localparam int ROOT_BITS  = N2_BITS / 2;
    localparam int SQRT_STEPS = ROOT_BITS;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUO_BITS;
    localparam int NUM_BITS   = NORM_BITS + FRAC_BITS;
    localparam int DLY        = SQRT_STEPS + DIV_STEPS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef word_t [2:0] vec3_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam word_t FX_ONE   = word_t'(1) <<< FRAC_BITS;

    typedef struct packed {
        vec3_t                       eye;
        vec3_t                       up;
        logic [2:0]                  neg;
        logic [2:0][NORM_BITS-1:0]   mn;
        logic                        degen;
    } meta_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] p;
        logic                 neg;
    } prod_t;

    typedef struct packed {
        word_t [3:0][3:0] col;
        logic             degen;
    } mat_t;

    function automatic logic [WORD_BITS-1:0] mag(word_t a);
        return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    endfunction

    function automatic prod_t mulp(word_t a, word_t b);
        prod_t r;
        r.p   = {{WORD_BITS{1'b0}}, mag(a)} * {{WORD_BITS{1'b0}}, mag(b)};
        r.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        return r;
    endfunction

    // drop fraction bits toward zero, then clamp to the word
    function automatic word_t fin(prod_t x);
        logic [PROD_BITS-FRAC_BITS-1:0] r;
        r = x.p[PROD_BITS-1:FRAC_BITS];
        if (r > (PROD_BITS-FRAC_BITS)'(WORD_MAX))
            return x.neg ? WORD_MIN : WORD_MAX;
        return x.neg ? -$signed(r[WORD_BITS-1:0]) : $signed(r[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_add(word_t a, word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_neg(word_t a);
        return (a == WORD_MIN) ? WORD_MAX : -a;
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        return sat_add(a, sat_neg(b));
    endfunction

endpackage

>>> hw/rtl/lav_isqrt.sv
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module lav_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [lav_pkg::N2_BITS-1:0]    n,
    output logic [lav_pkg::ROOT_BITS-1:0]  root
);
    import lav_pkg::*;

    logic [N2_BITS-1:0] rem_reg  [SQRT_STEPS];
    logic [N2_BITS-1:0] res_reg  [SQRT_STEPS];
    logic [N2_BITS-1:0] rem_next [SQRT_STEPS];
    logic [N2_BITS-1:0] res_next [SQRT_STEPS];
    logic [N2_BITS-1:0] rem_src  [SQRT_STEPS];
    logic [N2_BITS-1:0] res_src  [SQRT_STEPS];

    always_comb begin
        rem_src[0] = n;
        res_src[0] = '0;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            rem_src[k] = rem_reg[k-1];
            res_src[k] = res_reg[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            logic [N2_BITS-1:0] bit_v;
            logic [N2_BITS-1:0] trial;
            bit_v = N2_BITS'(1) << (2 * (SQRT_STEPS - 1 - k));
            trial = res_src[k] + bit_v;
            if (rem_src[k] >= trial) begin
                rem_next[k] = rem_src[k] - trial;
                res_next[k] = (res_src[k] >> 1) + bit_v;
            end else begin
                rem_next[k] = rem_src[k];
                res_next[k] = res_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][ROOT_BITS-1:0];

endmodule

>>> hw/rtl/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lav_div (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [lav_pkg::NUM_BITS-1:0]   num,
    input  logic [lav_pkg::ROOT_BITS-1:0]  den,
    output logic [lav_pkg::QUO_BITS-1:0]   quo
);
    import lav_pkg::*;

    localparam int RW = NUM_BITS + 2;

    logic [RW-1:0]        rem_reg  [DIV_STEPS];
    logic [ROOT_BITS-1:0] den_reg  [DIV_STEPS];
    logic [QUO_BITS-1:0]  quo_reg  [DIV_STEPS];
    logic [RW-1:0]        rem_next [DIV_STEPS];
    logic [QUO_BITS-1:0]  quo_next [DIV_STEPS];
    logic [RW-1:0]        rem_src  [DIV_STEPS];
    logic [ROOT_BITS-1:0] den_src  [DIV_STEPS];
    logic [QUO_BITS-1:0]  quo_src  [DIV_STEPS];

    always_comb begin
        rem_src[0] = RW'(num);
        den_src[0] = den;
        quo_src[0] = '0;
        for (int k = 1; k < DIV_STEPS; k++) begin
            rem_src[k] = rem_reg[k-1];
            den_src[k] = den_reg[k-1];
            quo_src[k] = quo_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [RW+QUO_BITS-1:0] d;
            d = (RW+QUO_BITS)'(den_src[k]) << (DIV_STEPS - 1 - k);
            quo_next[k] = quo_src[k];
            rem_next[k] = rem_src[k];
            if ((RW+QUO_BITS)'(rem_src[k]) >= d) begin
                rem_next[k] = rem_src[k] - d[RW-1:0];
                quo_next[k][DIV_STEPS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

>>> hw/rtl/lav_colser.sv
// ----------------------------------------------------------------------------
// lav_colser
// Holds one finished matrix and sends it out as four column items.
// ----------------------------------------------------------------------------
module lav_colser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  lav_pkg::mat_t             in_mat,
    output logic                      load,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_column_index,
    output lav_pkg::word_t            m_elem_0,
    output lav_pkg::word_t            m_elem_1,
    output lav_pkg::word_t            m_elem_2,
    output lav_pkg::word_t            m_elem_3,
    output logic                      m_last_column,
    output logic                      m_degenerate
);
    import lav_pkg::*;

    localparam logic [1:0] LAST_COL = 2'd3;

    mat_t       mat_reg;
    logic       busy_reg, busy_next;
    logic [1:0] cnt_reg, cnt_next;

    assign load = !busy_reg || (m_ready && cnt_reg == LAST_COL);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && m_ready)
            cnt_next = cnt_reg + 2'd1;
        if (load) begin
            busy_next = in_valid;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid)
            mat_reg <= in_mat;
    end

    assign m_valid        = busy_reg;
    assign m_column_index = cnt_reg;
    assign m_elem_0       = mat_reg.col[cnt_reg][0];
    assign m_elem_1       = mat_reg.col[cnt_reg][1];
    assign m_elem_2       = mat_reg.col[cnt_reg][2];
    assign m_elem_3       = mat_reg.col[cnt_reg][3];
    assign m_last_column  = (cnt_reg == LAST_COL);
    assign m_degenerate   = mat_reg.degen;

    a_first_col: assert property (@(posedge aclk) disable iff (!aresetn)
        load && in_valid |=> m_valid && m_column_index == 2'd0)
        else $error("new matrix did not start at column 0");
    a_keep_going: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_column |=> m_valid)
        else $error("matrix dropped before its last column");
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_elem_0 == 0 && m_elem_1 == 0 &&
                                    m_elem_2 == 0 && m_elem_3 == 0)
        else $error("degenerate matrix has nonzero element");

endmodule

>>> hw/rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed Q16.16, four column items out.
// ----------------------------------------------------------------------------
// Takes one camera item (eye, target, up) and returns four column items in
// stored order, column 3 carrying the translation and last_column. Sustained
// rate is set by the single result channel that carries four columns per
// item and can be held by m_ready; the pipeline behind it accepts an item
// in any cycle it is not stalled. On the way to the first column an item
// passes four setup stages, a 31-stage square root, a 17-stage divider,
// then eight stages of products and saturating sums.
module look_at_view_matrix (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lav_pkg::word_t   s_eye_x,
    input  lav_pkg::word_t   s_eye_y,
    input  lav_pkg::word_t   s_eye_z,
    input  lav_pkg::word_t   s_target_x,
    input  lav_pkg::word_t   s_target_y,
    input  lav_pkg::word_t   s_target_z,
    input  lav_pkg::word_t   s_up_x,
    input  lav_pkg::word_t   s_up_y,
    input  lav_pkg::word_t   s_up_z,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_column_index,
    output lav_pkg::word_t   m_elem_0,
    output lav_pkg::word_t   m_elem_1,
    output lav_pkg::word_t   m_elem_2,
    output lav_pkg::word_t   m_elem_3,
    output logic             m_last_column,
    output logic             m_degenerate
);
    import lav_pkg::*;

    typedef struct packed {
        vec3_t eye;
        vec3_t x;
        vec3_t y;
        vec3_t z;
        vec3_t up;
        logic  degen;
    } geo_t;

    logic en, load;

    // stage A: differences
    vec3_t                   a_eye_reg, a_up_reg;
    logic [2:0]              a_neg_reg;
    logic [2:0][WORD_BITS-1:0] a_m_reg;
    // stage B..D
    meta_t                   b_meta_reg, c_meta_reg, d_meta_reg;
    logic [2:0][SQ_BITS-1:0] c_sq_reg;
    logic [N2_BITS-1:0]      d_n2_reg;
    meta_t                   dly_reg [DLY];
    // back end
    geo_t                    e_reg, m1_reg, x_reg, m2_reg, y_reg, m3_reg, d1_reg;
    prod_t [5:0]             p1_reg, p2_reg;
    prod_t [8:0]             p3_reg;
    vec3_t                   part_reg, third_reg;
    mat_t                    d2_reg;

    logic [3:0]              fv_reg;     // A..D
    logic [DLY-1:0]          vdly_reg;
    logic [7:0]              bv_reg;     // E, M1, X, M2, Y, M3, D1, D2

    logic [ROOT_BITS-1:0]    root;
    logic [2:0][QUO_BITS-1:0] quo;

    assign en      = !bv_reg[7] || load;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg   <= '0;
            vdly_reg <= '0;
            bv_reg   <= '0;
        end else if (en) begin
            fv_reg   <= {fv_reg[2:0], s_valid};
            vdly_reg <= {vdly_reg[DLY-2:0], fv_reg[3]};
            bv_reg   <= {bv_reg[6:0], vdly_reg[DLY-1]};
        end
    end

    // stage A
    always_ff @(posedge aclk) begin
        if (en) begin
            vec3_t e, t;
            e = {s_eye_z, s_eye_y, s_eye_x};
            t = {s_target_z, s_target_y, s_target_x};
            for (int i = 0; i < 3; i++) begin
                logic signed [WORD_BITS:0] d;
                d = {e[i][WORD_BITS-1], e[i]} - {t[i][WORD_BITS-1], t[i]};
                a_neg_reg[i] <= d[WORD_BITS];
                a_m_reg[i]   <= d[WORD_BITS] ? WORD_BITS'(-d) : WORD_BITS'(d);
            end
            a_eye_reg <= e;
            a_up_reg  <= {s_up_z, s_up_y, s_up_x};
        end
    end

    // stage B: scale magnitudes so the largest has its top bit at NORM_BITS-1
    logic [WORD_BITS-1:0] big;
    logic [LEAD_BITS-1:0] lead;
    always_comb begin
        big = a_m_reg[0];
        if (a_m_reg[1] > big) big = a_m_reg[1];
        if (a_m_reg[2] > big) big = a_m_reg[2];
        lead = '0;
        for (int i = 0; i < WORD_BITS; i++)
            if (big[i]) lead = LEAD_BITS'(i);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (lead >= LEAD_BITS'(NORM_BITS-1))
                    b_meta_reg.mn[i] <=
                        NORM_BITS'(a_m_reg[i] >> (lead - LEAD_BITS'(NORM_BITS-1)));
                else
                    b_meta_reg.mn[i] <=
                        NORM_BITS'(a_m_reg[i] << (LEAD_BITS'(NORM_BITS-1) - lead));
            end
            b_meta_reg.eye   <= a_eye_reg;
            b_meta_reg.up    <= a_up_reg;
            b_meta_reg.neg   <= a_neg_reg;
            b_meta_reg.degen <= (big == '0);
        end
    end

    // stage C: squares, stage D: sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++)
                c_sq_reg[i] <= SQ_BITS'(b_meta_reg.mn[i]) * SQ_BITS'(b_meta_reg.mn[i]);
            c_meta_reg <= b_meta_reg;
            d_n2_reg   <= N2_BITS'(c_sq_reg[0]) + N2_BITS'(c_sq_reg[1])
                        + N2_BITS'(c_sq_reg[2]);
            d_meta_reg <= c_meta_reg;
        end
    end

    // hold side data alongside the root and divider pipelines
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= d_meta_reg;
            for (int k = 1; k < DLY; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    lav_isqrt u_isqrt (.aclk(aclk), .en(en), .n(d_n2_reg), .root(root));

    for (genvar i = 0; i < 3; i++) begin : g_div
        lav_div u_div (
            .aclk(aclk),
            .en  (en),
            .num ({dly_reg[SQRT_STEPS-1].mn[i], {FRAC_BITS{1'b0}}}),
            .den (root),
            .quo (quo[i])
        );
    end

    // back end: forward axis, two cross products, three dots
    always_ff @(posedge aclk) begin
        if (en) begin
            meta_t md;
            geo_t  xn;
            geo_t  yn;
            md = dly_reg[DLY-1];
            // E
            for (int i = 0; i < 3; i++) begin
                e_reg.z[i] <= md.neg[i] ? -$signed(WORD_BITS'(quo[i]))
                                        : $signed(WORD_BITS'(quo[i]));
            end
            e_reg.eye   <= md.eye;
            e_reg.up    <= md.up;
            e_reg.x     <= '0;
            e_reg.y     <= '0;
            e_reg.degen <= md.degen;
            // M1: up x z
            p1_reg[0] <= mulp(e_reg.up[1], e_reg.z[2]);
            p1_reg[1] <= mulp(e_reg.up[2], e_reg.z[1]);
            p1_reg[2] <= mulp(e_reg.up[2], e_reg.z[0]);
            p1_reg[3] <= mulp(e_reg.up[0], e_reg.z[2]);
            p1_reg[4] <= mulp(e_reg.up[0], e_reg.z[1]);
            p1_reg[5] <= mulp(e_reg.up[1], e_reg.z[0]);
            m1_reg    <= e_reg;
            // X
            xn = m1_reg;
            for (int i = 0; i < 3; i++)
                xn.x[i] = sat_sub(fin(p1_reg[2*i]), fin(p1_reg[2*i+1]));
            x_reg <= xn;
            // M2: z x x
            p2_reg[0] <= mulp(x_reg.z[1], x_reg.x[2]);
            p2_reg[1] <= mulp(x_reg.z[2], x_reg.x[1]);
            p2_reg[2] <= mulp(x_reg.z[2], x_reg.x[0]);
            p2_reg[3] <= mulp(x_reg.z[0], x_reg.x[2]);
            p2_reg[4] <= mulp(x_reg.z[0], x_reg.x[1]);
            p2_reg[5] <= mulp(x_reg.z[1], x_reg.x[0]);
            m2_reg    <= x_reg;
            // Y
            yn = m2_reg;
            for (int i = 0; i < 3; i++)
                yn.y[i] = sat_sub(fin(p2_reg[2*i]), fin(p2_reg[2*i+1]));
            y_reg <= yn;
            // M3: eye against each axis
            for (int i = 0; i < 3; i++) begin
                p3_reg[i]     <= mulp(y_reg.eye[i], y_reg.x[i]);
                p3_reg[3 + i] <= mulp(y_reg.eye[i], y_reg.y[i]);
                p3_reg[6 + i] <= mulp(y_reg.eye[i], y_reg.z[i]);
            end
            m3_reg <= y_reg;
            // D1
            for (int j = 0; j < 3; j++) begin
                part_reg[j]  <= sat_add(fin(p3_reg[3*j]), fin(p3_reg[3*j+1]));
                third_reg[j] <= fin(p3_reg[3*j+2]);
            end
            d1_reg <= m3_reg;
            // D2: assemble columns, zero everything when eye equals target
            for (int k = 0; k < 3; k++) begin
                d2_reg.col[k][0] <= d1_reg.degen ? word_t'(0) : d1_reg.x[k];
                d2_reg.col[k][1] <= d1_reg.degen ? word_t'(0) : d1_reg.y[k];
                d2_reg.col[k][2] <= d1_reg.degen ? word_t'(0) : d1_reg.z[k];
                d2_reg.col[k][3] <= '0;
                d2_reg.col[3][k] <= d1_reg.degen ? word_t'(0)
                                  : sat_neg(sat_add(part_reg[k], third_reg[k]));
            end
            d2_reg.col[3][3] <= d1_reg.degen ? word_t'(0) : FX_ONE;
            d2_reg.degen     <= d1_reg.degen;
        end
    end

    lav_colser u_colser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (bv_reg[7]),
        .in_mat        (d2_reg),
        .load          (load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column_index(m_column_index),
        .m_elem_0      (m_elem_0),
        .m_elem_1      (m_elem_1),
        .m_elem_2      (m_elem_2),
        .m_elem_3      (m_elem_3),
        .m_last_column (m_last_column),
        .m_degenerate  (m_degenerate)
    );

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(bv_reg) && $stable(vdly_reg) && $stable(fv_reg))
        else $error("pipeline valid bits moved during a stall");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !bv_reg[7] |-> s_ready)
        else $error("input stalled with an empty pipeline tail");
    a_hand_over: assert property (@(posedge aclk) disable iff (!aresetn)
        bv_reg[7] && load |=> m_valid)
        else $error("finished matrix lost at hand-over");

endmodule
